// ----- design/life_grid_engine_top_defines.svh -----
// ----------------------------------------------------------------------------
// Life grid engine assertion macros
// Shared property shapes for the port-level checker of the life grid engine.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_ENGINE_TOP_DEFINES_SVH
`define LIFE_GRID_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LGE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define LGE_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lge_pkg.sv -----
// ----------------------------------------------------------------------------
// Life grid engine package
// Sizes, command and register codes, and shared types of the life grid engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lge_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int DIM_W     = 7;
  localparam int CMD_W     = 2;
  localparam int COORD_W   = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  typedef logic [MAX_WIDTH-1:0] lge_row_t;

  // Three-by-three neighborhood of one cell; bit 1 of mid is the cell itself.
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] mid;
    logic [2:0] below;
  } lge_window_t;

endpackage

`default_nettype wire

// ----- design/lge_cell_unit.sv -----
// ----------------------------------------------------------------------------
// Life grid engine cell unit
// Counts the eight neighbors of one cell and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
`default_nettype none

module lge_cell_unit import lge_pkg::*; (
  input  lge_window_t win,
  output logic        alive_next
);

  logic [3:0] count;

  assign count = 4'(win.above[0]) + 4'(win.above[1]) + 4'(win.above[2])
               + 4'(win.mid[0])   + 4'(win.mid[2])
               + 4'(win.below[0]) + 4'(win.below[1]) + 4'(win.below[2]);

  assign alive_next = (count == 4'd3) || ((count == 4'd2) && win.mid[1]);

endmodule

`default_nettype wire

// ----- design/lge_row_ram.sv -----
// ----------------------------------------------------------------------------
// Life grid engine row memory
// One row of cells per entry, registered read, per-row valid bits so that
// rows not written since reset read as dead.
// ----------------------------------------------------------------------------
`default_nettype none

module lge_row_ram import lge_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [YW-1:0] rd_addr,
  output lge_row_t      rd_data,
  input  logic          wr_en,
  input  logic [YW-1:0] wr_addr,
  input  lge_row_t      wr_data
);

  lge_row_t                mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0]   row_valid;
  lge_row_t                rd_data_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid_q <= row_valid[rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- design/life_grid_engine_top.sv -----
// ----------------------------------------------------------------------------
// Life grid engine top level
// Bounded Game of Life grid with cell write, cell read and one-generation step.
// ----------------------------------------------------------------------------
// Input beats carry command, cell_x, cell_y and cell_value on in_valid/in_stall.
// Every input beat yields exactly one output beat of read_value and range_error
// on out_valid/out_stall. Grid size is set by cfg_write with cfg_index 0 for
// the width and 1 for the height; the user must write it only while the block
// is idle, and the block itself does not enforce this.
// A read or write inside the grid passes through S_RW and then S_RESULT; a
// position outside the grid, an unused command or an empty step goes straight
// to S_RESULT. A generation step uses the single cell unit, which evaluates one
// cell per cycle while the sequencer walks the grid row by row.
// The block takes one beat at a time and holds in_stall high until its result
// sits in the output register. A stalled output beat is held, and a finished
// result waits for a free register.
// Reset clears the grid to all dead, sets the size to 64 by 64 and empties
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_engine_top import lge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     command,
  input  logic [COORD_W-1:0]   cell_x,
  input  logic [COORD_W-1:0]   cell_y,
  input  logic                 cell_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 read_value,
  output logic                 range_error
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RW,
    S_ADV_START,
    S_ADV_FIRST,
    S_ADV_NEXT,
    S_ADV_CELL,
    S_ADV_WB,
    S_RESULT
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic [CMD_W-1:0] cmd_q;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  logic             bit_q;
  logic             pend_rd;
  logic             pend_err;
  lge_row_t         prev;
  lge_row_t         cur;
  lge_row_t         nxt;
  lge_row_t         new_row;

  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic             in_range;
  logic             accept;
  logic             out_free;
  logic [YW-1:0]    rd_addr;
  lge_row_t         rd_row;
  logic             wr_en;
  logic [YW-1:0]    wr_addr;
  lge_row_t         wr_row;
  lge_row_t         patched_row;
  logic             lft_ok;
  logic             rgt_ok;
  logic [XW-1:0]    xl;
  logic [XW-1:0]    xr;
  lge_window_t      win;
  logic             cell_next;

  assign eff_w = (32'(grid_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : grid_width;
  assign eff_h = (32'(grid_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : grid_height;

  assign in_range = (32'(cell_x) < 32'(eff_w)) && (32'(cell_y) < 32'(eff_h));
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (state)
      S_IDLE:      rd_addr = YW'(cell_y);
      S_ADV_FIRST: rd_addr = YW'(1);
      S_ADV_WB:    rd_addr = YW'(32'(y) + 2);
      default:     rd_addr = '0;
    endcase
  end

  always_comb begin
    patched_row    = rd_row;
    patched_row[x] = bit_q;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = y;
    wr_row  = new_row;
    if (state == S_RW && cmd_q == CMD_WRITE) begin
      wr_en  = 1'b1;
      wr_row = patched_row;
    end else if (state == S_ADV_WB) begin
      wr_en = 1'b1;
    end
  end

  assign lft_ok = (x != '0);
  assign rgt_ok = (32'(x) + 1) < 32'(eff_w);
  assign xl     = XW'(32'(x) - 1);
  assign xr     = XW'(32'(x) + 1);

  assign win.above = {rgt_ok & prev[xr], prev[x], lft_ok & prev[xl]};
  assign win.mid   = {rgt_ok & cur[xr],  cur[x],  lft_ok & cur[xl]};
  assign win.below = {rgt_ok & nxt[xr],  nxt[x],  lft_ok & nxt[xl]};

  lge_row_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  lge_cell_unit u_cell (
    .win        (win),
    .alive_next (cell_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      grid_width  <= DIM_RESET;
      grid_height <= DIM_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= command;
            x        <= XW'(cell_x);
            bit_q    <= cell_value;
            pend_rd  <= 1'b0;
            pend_err <= 1'b0;
            case (command)
              CMD_WRITE, CMD_READ: begin
                y <= YW'(cell_y);
                if (in_range) begin
                  state <= S_RW;
                end else begin
                  pend_err <= 1'b1;
                  state    <= S_RESULT;
                end
              end
              CMD_STEP: begin
                y <= '0;
                if (eff_w == '0 || eff_h == '0) begin
                  state <= S_RESULT;
                end else begin
                  state <= S_ADV_START;
                end
              end
              default: state <= S_RESULT;
            endcase
          end
        end
        S_RW: begin
          if (cmd_q == CMD_READ) begin
            pend_rd <= rd_row[x];
          end
          state <= S_RESULT;
        end
        S_ADV_START: begin
          state <= S_ADV_FIRST;
        end
        S_ADV_FIRST: begin
          cur   <= rd_row;
          prev  <= '0;
          state <= S_ADV_NEXT;
        end
        S_ADV_NEXT: begin
          nxt     <= ((32'(y) + 1) < 32'(eff_h)) ? rd_row : '0;
          new_row <= cur;
          x       <= '0;
          state   <= S_ADV_CELL;
        end
        S_ADV_CELL: begin
          new_row[x] <= cell_next;
          if ((32'(x) + 1) >= 32'(eff_w)) begin
            state <= S_ADV_WB;
          end else begin
            x <= x + 1'b1;
          end
        end
        S_ADV_WB: begin
          prev <= cur;
          cur  <= nxt;
          if ((32'(y) + 1) >= 32'(eff_h)) begin
            state <= S_RESULT;
          end else begin
            y     <= y + 1'b1;
            state <= S_ADV_NEXT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            read_value  <= pend_rd;
            range_error <= pend_err;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/lge_checker.sv -----
// ----------------------------------------------------------------------------
// Life grid engine port checker
// Watches the top-level ports of the life grid engine over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_grid_engine_top_defines.svh"

module lge_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic read_value,
  input wire logic range_error
);

  `LGE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output beat dropped while stalled")
  `LGE_ASSERT_SAME(a_flags_excl, out_valid, !(read_value && range_error), "read value with range error")
  `LGE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second beat taken at once")
  `LGE_ASSERT_RESET(a_reset_empty, rst, !out_valid, "output beat right after reset")

endmodule

bind life_grid_engine_top lge_checker u_lge_checker (.*);

`default_nettype wire

// ----- bench/life_grid_engine_top_tb.sv -----
// ----------------------------------------------------------------------------
// Life grid engine testbench
// Drives cell writes, cell reads, generation steps and unused commands into
// the life grid engine under several grid sizes and idle patterns. A local
// copy of the grid predicts every result beat, and the monitor checks each
// one in order against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_engine_top_tb import lge_pkg::*; ();

  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int                   LONG_HOLD  = 200;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               v;
  } cell_beat_t;

  typedef struct {
    logic read_value;
    logic range_error;
  } cell_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     command = '0;
  logic [COORD_W-1:0]   cell_x = '0;
  logic [COORD_W-1:0]   cell_y = '0;
  logic                 cell_value = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 read_value;
  logic                 range_error;

  cell_beat_t   pending_beats[$];
  cell_beat_t   offered_beat;
  cell_result_t awaited_results[$];

  bit               life_cells [MAX_HEIGHT][MAX_WIDTH];
  logic [DIM_W-1:0] model_width = DIM_RESET;
  logic [DIM_W-1:0] model_height = DIM_RESET;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   mismatch_count = 0;
  bit   hold_off_armed = 1'b0;
  logic rx_hold = 1'b0;

  life_grid_engine_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .range_error(range_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int cols_in_use();
    return (model_width > MAX_WIDTH) ? MAX_WIDTH : int'(model_width);
  endfunction

  function automatic int rows_in_use();
    return (model_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(model_height);
  endfunction

  function automatic void advance_generation();
    bit prev [MAX_HEIGHT][MAX_WIDTH];
    int cols;
    int rows;
    int n;
    prev = life_cells;
    cols = cols_in_use();
    rows = rows_in_use();
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < rows &&
                c + dc >= 0 && c + dc < cols) begin
              n += prev[r + dr][c + dc];
            end
          end
        end
        if (n == 3) begin
          life_cells[r][c] = 1'b1;
        end else if (n != 2) begin
          life_cells[r][c] = 1'b0;
        end
      end
    end
  endfunction

  function automatic void apply_command(input cell_beat_t b);
    cell_result_t res;
    res = '{1'b0, 1'b0};
    case (b.cmd)
      CMD_WRITE, CMD_READ: begin
        if (b.x >= cols_in_use() || b.y >= rows_in_use()) begin
          res.range_error = 1'b1;
        end else if (b.cmd == CMD_WRITE) begin
          life_cells[b.y][b.x] = b.v;
        end else begin
          res.read_value = life_cells[b.y][b.x];
        end
      end
      CMD_STEP: begin
        advance_generation();
      end
      default: begin
      end
    endcase
    awaited_results.push_back(res);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(offered_beat);
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_beat = pending_beats.pop_front();
          in_valid   <= 1'b1;
          command    <= offered_beat.cmd;
          cell_x     <= offered_beat.x;
          cell_y     <= offered_beat.y;
          cell_value <= offered_beat.v;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cell_result_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with no expected result");
        end else begin
          exp_res = awaited_results.pop_front();
          if (read_value !== exp_res.read_value) begin
            report_mismatch($sformatf("read_value %b, expected %b",
                                      read_value, exp_res.read_value));
          end
          if (range_error !== exp_res.range_error) begin
            report_mismatch($sformatf("range_error %b, expected %b",
                                      range_error, exp_res.range_error));
          end
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The receiver holds off for a long stretch while the sender keeps offering.
  initial begin
    wait (hold_off_armed);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic queue_beat(input logic [CMD_W-1:0] cmd, input int x, input int y,
                            input logic v);
    cell_beat_t b;
    b.cmd = cmd;
    b.x   = x[COORD_W-1:0];
    b.y   = y[COORD_W-1:0];
    b.v   = v;
    pending_beats.push_back(b);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_beats.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic program_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= DIM_W'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    model_width  = w;
    model_height = h;
    @(negedge clk);
  endtask

  task automatic queue_random_beat();
    int pick;
    int cols;
    int rows;
    pick = $urandom_range(99);
    cols = cols_in_use();
    rows = rows_in_use();
    if (pick < 44) begin
      queue_beat(CMD_WRITE, $urandom_range(cols - 1), $urandom_range(rows - 1),
                 $urandom_range(99) < 45);
    end else if (pick < 72) begin
      queue_beat(CMD_READ, $urandom_range(cols - 1), $urandom_range(rows - 1),
                 $urandom_range(1));
    end else if (pick < 85) begin
      queue_beat(CMD_STEP, $urandom_range(63), $urandom_range(63), $urandom_range(1));
    end else if (pick < 95) begin
      queue_beat($urandom_range(1) ? CMD_WRITE : CMD_READ, $urandom_range(63),
                 $urandom_range(63), $urandom_range(1));
    end else begin
      queue_beat(CMD_UNUSED, $urandom_range(63), $urandom_range(63), $urandom_range(1));
    end
  endtask

  task automatic run_random_phase(input int count, input int w, input int h,
                                  input int idle, input int stall);
    wait_drained();
    program_grid(w[DIM_W-1:0], h[DIM_W-1:0]);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) queue_random_beat();
  endtask

  initial begin
    wait (rst == 1'b0);
    @(negedge clk);

    // Corner patterns and a blinker on the full-size grid after reset.
    queue_beat(CMD_WRITE, 0, 0, 1'b1);
    queue_beat(CMD_WRITE, 1, 0, 1'b1);
    queue_beat(CMD_WRITE, 0, 1, 1'b1);
    queue_beat(CMD_WRITE, 63, 63, 1'b1);
    queue_beat(CMD_WRITE, 63, 62, 1'b1);
    queue_beat(CMD_WRITE, 62, 63, 1'b1);
    queue_beat(CMD_WRITE, 30, 20, 1'b1);
    queue_beat(CMD_WRITE, 31, 20, 1'b1);
    queue_beat(CMD_WRITE, 32, 20, 1'b1);
    queue_beat(CMD_READ, 0, 0, 1'b0);
    queue_beat(CMD_READ, 63, 63, 1'b1);
    queue_beat(CMD_UNUSED, 63, 63, 1'b1);
    queue_beat(CMD_STEP, 0, 0, 1'b0);
    queue_beat(CMD_READ, 1, 1, 1'b0);
    queue_beat(CMD_READ, 62, 62, 1'b0);
    queue_beat(CMD_READ, 31, 19, 1'b0);
    queue_beat(CMD_READ, 30, 20, 1'b0);

    // An empty grid rejects every access and a step changes nothing.
    wait_drained();
    program_grid(7'd0, 7'd5);
    queue_beat(CMD_WRITE, 0, 0, 1'b1);
    queue_beat(CMD_READ, 0, 0, 1'b0);
    queue_beat(CMD_STEP, 0, 0, 1'b0);

    // Oversized registers are capped at the maximum grid size.
    wait_drained();
    program_grid(7'd127, 7'd127);
    queue_beat(CMD_READ, 63, 63, 1'b0);
    queue_beat(CMD_STEP, 0, 0, 1'b0);

    wait_drained();
    program_grid(7'd1, 7'd1);
    queue_beat(CMD_WRITE, 0, 0, 1'b1);
    queue_beat(CMD_READ, 1, 0, 1'b0);
    queue_beat(CMD_STEP, 0, 0, 1'b0);
    queue_beat(CMD_READ, 0, 0, 1'b0);

    run_random_phase(22, $urandom_range(3, 12), $urandom_range(3, 12), 0, 0);
    run_random_phase(22, 64, 3, 52, 0);
    run_random_phase(22, $urandom_range(2, 12), $urandom_range(2, 12), 0, 52);
    run_random_phase(22, 100, 4, 33, 33);

    // Long receiver hold while the sender keeps offering, then a full drain
    // before the sender resumes.
    wait_drained();
    program_grid(7'd16, 7'd8);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_armed = 1'b1;
    repeat (14) queue_random_beat();
    wait_drained();
    repeat (14) queue_random_beat();

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/lge_pkg.sv
design/lge_cell_unit.sv
design/lge_row_ram.sv
design/life_grid_engine_top.sv
design/lge_checker.sv
bench/life_grid_engine_top_tb.sv
